// ===== rtl/frequency_table_mode_finder_defines.svh =====
// Assertion macros used by the frequency table mode finder RTL.
`ifndef FREQUENCY_TABLE_MODE_FINDER_DEFINES_SVH
`define FREQUENCY_TABLE_MODE_FINDER_DEFINES_SVH

`ifndef SYNTH
// Condition implies a consequence in the same cycle.
`define FQM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Condition implies a consequence in the next cycle.
`define FQM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FQM_ASSERT_IMPL(lbl, ante, cons)
`define FQM_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/fqm_pkg.sv =====
// Package: sizes and shared types of the frequency table mode finder.
`default_nettype none

package fqm_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ID_BITS       = 16;
    localparam int COUNT_BITS    = 32;
    localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);

    // Field widths of the stream payloads
    localparam int IN_TDATA_BITS  = ((ID_BITS + 7) / 8) * 8;
    localparam int OUT_RAW_BITS   = ID_BITS + COUNT_BITS + USED_BITS + 1;
    localparam int OUT_TDATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // Running best entry handed along the chain during the result sweep
    typedef struct packed {
        logic [ID_BITS-1:0]    id;
        logic [COUNT_BITS-1:0] count;
    } t_best;

    // Controls broadcast from the top level to every cell
    typedef struct packed {
        logic               item;    // an item beat is accepted this cycle
        logic [ID_BITS-1:0] id;      // identifier of that beat
        logic               new_id;  // no cell holds the identifier
        logic               adv;     // sweep token and best values may move
    } t_cell_ctl;

endpackage

`default_nettype wire

// ===== rtl/fqm_cell.sv =====
// One table cell: holds an identifier and its count, joins the result sweep.
`default_nettype none

module fqm_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire fqm_pkg::t_cell_ctl i_ctl,
    input  wire                 i_prev_valid,
    input  wire                 i_token,
    input  wire fqm_pkg::t_best i_best,
    output logic                o_valid,
    output logic                o_match,
    output logic                o_token,
    output fqm_pkg::t_best      o_best
);
    import fqm_pkg::*;

    logic                  r_valid;
    logic                  r_token;
    logic [ID_BITS-1:0]    r_id;
    logic [COUNT_BITS-1:0] r_count;
    t_best                 r_best;
    t_best                 n_best;
    logic                  w_insert;

    assign o_match  = r_valid && (r_id == i_ctl.id);
    // first free cell: left neighbor in use, this one not
    assign w_insert = i_ctl.item && i_ctl.new_id && !r_valid && i_prev_valid;

    // own entry wins only on a strictly higher count, so earlier cells keep ties
    always_comb begin
        if (r_valid && (r_count > i_best.count)) begin
            n_best.id    = r_id;
            n_best.count = r_count;
        end else begin
            n_best = i_best;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_token <= 1'b0;
        end else begin
            if (i_ctl.adv) begin
                r_token <= i_token;
            end
            if (i_ctl.adv && i_token) begin
                r_valid <= 1'b0;
            end else if (w_insert) begin
                r_valid <= 1'b1;
            end
        end
    end

    // entry payload and sweep value
    always_ff @(posedge i_clk) begin
        if (w_insert) begin
            r_id    <= i_ctl.id;
            r_count <= {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end else if (i_ctl.item && o_match && (r_count != COUNT_MAX)) begin
            r_count <= r_count + {{(COUNT_BITS-1){1'b0}}, 1'b1};
        end
        if (i_ctl.adv && i_token) begin
            r_best <= n_best;
        end
    end

    assign o_valid = r_valid;
    assign o_token = r_token;
    assign o_best  = r_best;

endmodule

`default_nettype wire

// ===== rtl/frequency_table_mode_finder.sv =====
// Top level: stream ports, table bookkeeping and the row of table cells.
`default_nettype none

// Counts item identifiers in a row of TABLE_ENTRIES cells and reports the
// most frequent one (earliest inserted on ties) after the beat marked tlast.
// Every identifier beat is taken as it arrives: all cells compare it at once
// and the matching cell counts it, or the first free cell stores it. After a
// tlast beat a token walks the cell row, one cell a cycle, carrying the best
// entry so far and clearing each cell behind it; the input is not ready until
// the result lands in the output register. The walk pauses while an older
// result is still waiting there.
module frequency_table_mode_finder (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // item_id [15:0]
    input  wire  [fqm_pkg::IN_TDATA_BITS-1:0]    i_s_tdata,
    // last_item
    input  wire                                  i_s_tlast,
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    // mode_id [15:0], mode_count [47:16], distinct_count [54:48],
    // table_overflow [55]
    output logic [fqm_pkg::OUT_TDATA_BITS-1:0]   o_m_tdata,
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready
);
    import fqm_pkg::*;

    `include "frequency_table_mode_finder_defines.svh"

    logic                   r_busy;
    logic                   r_start;
    logic                   r_ovf;
    logic [USED_BITS-1:0]   r_used;
    logic [USED_BITS-1:0]   r_sum_used;
    logic                   r_sum_ovf;
    logic                   r_out_valid;
    logic [OUT_RAW_BITS-1:0] r_out;

    t_cell_ctl              w_ctl;
    logic                   w_accept;
    logic                   w_any_match;
    logic                   w_full;
    logic                   w_insert;
    logic                   w_ovf_now;
    logic [USED_BITS-1:0]   n_used;

    logic [TABLE_ENTRIES-1:0] w_valid;
    logic [TABLE_ENTRIES-1:0] w_match;
    logic [TABLE_ENTRIES-1:0] w_token;
    t_best                    w_best [TABLE_ENTRIES];
    t_best                    w_best_zero;

    assign o_s_tready  = !r_busy;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_any_match = |w_match;
    assign w_full      = w_valid[TABLE_ENTRIES-1];
    assign w_insert    = w_accept && !w_any_match && !w_full;
    assign w_ovf_now   = w_accept && !w_any_match && w_full;
    assign n_used      = r_used + {{(USED_BITS-1){1'b0}}, w_insert};
    assign w_best_zero = '0;

    // broadcast to the cells
    always_comb begin
        w_ctl.item   = w_accept;
        w_ctl.id     = i_s_tdata[ID_BITS-1:0];
        w_ctl.new_id = !w_any_match;
        w_ctl.adv    = !r_out_valid || i_m_tready;
    end

    // cell row
    for (genvar k = 0; k < TABLE_ENTRIES; k++) begin : g_cell
        fqm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev_valid ((k == 0) ? 1'b1 : w_valid[(k == 0) ? 0 : k-1]),
            .i_token      ((k == 0) ? r_start : w_token[(k == 0) ? 0 : k-1]),
            .i_best       ((k == 0) ? w_best_zero : w_best[(k == 0) ? 0 : k-1]),
            .o_valid      (w_valid[k]),
            .o_match      (w_match[k]),
            .o_token      (w_token[k]),
            .o_best       (w_best[k])
        );
    end

    // set bookkeeping, sweep control and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_start     <= 1'b0;
            r_ovf       <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept && i_s_tlast) begin
                r_busy  <= 1'b1;
                r_start <= 1'b1;
                r_used  <= '0;
                r_ovf   <= 1'b0;
            end else if (w_accept) begin
                r_used  <= n_used;
                r_ovf   <= r_ovf || w_ovf_now;
            end
            if (r_start && w_ctl.adv) begin
                r_start <= 1'b0;
            end
            if (w_ctl.adv && w_token[TABLE_ENTRIES-1]) begin
                r_busy      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_accept && i_s_tlast) begin
            r_sum_used <= n_used;
            r_sum_ovf  <= r_ovf || w_ovf_now;
        end
        if (w_ctl.adv && w_token[TABLE_ENTRIES-1]) begin
            r_out <= {r_sum_ovf, r_sum_used, w_best[TABLE_ENTRIES-1].count,
                      w_best[TABLE_ENTRIES-1].id};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_BITS'(r_out);

    // no sweep token anywhere while items are being taken
    `FQM_ASSERT_IMPL(a_idle_no_token, !r_busy, (w_token == '0) && !r_start)
    // at most one sweep token in flight
    `FQM_ASSERT_IMPL(a_one_token, r_busy, $onehot0({w_token, r_start}))
    // cells fill in order, without gaps, while items are being taken
    `FQM_ASSERT_IMPL(a_packed_fill, !r_busy, ((w_valid >> 1) & ~w_valid) == '0)
    // distinct counter agrees with the cells in use
    `FQM_ASSERT_IMPL(a_used_count, !r_busy, $countones(w_valid) == int'(r_used))
    // a tlast beat starts the sweep
    `FQM_ASSERT_NEXT(a_last_starts, w_accept && i_s_tlast, r_busy && r_start)

endmodule

`default_nettype wire

// ===== dv/frequency_table_mode_finder_test.sv =====
// Stream testbench for the frequency table mode finder: random sets checked against a table predictor.
`timescale 1ns / 100ps

module frequency_table_mode_finder_test;

    import fqm_pkg::*;

    // One mode report, packed like o_m_tdata (mode_id in the lowest bits)
    typedef struct packed {
        logic                  overflow;
        logic [USED_BITS-1:0]  distinct;
        logic [COUNT_BITS-1:0] count;
        logic [ID_BITS-1:0]    id;
    } mode_report_t;

    // Tracks the identifier table of the current set and the reports it owes
    class mode_tally;
        logic [ID_BITS-1:0]    ids[TABLE_ENTRIES];
        logic [COUNT_BITS-1:0] counts[TABLE_ENTRIES];
        int                    used;
        bit                    dropped;
        mode_report_t          owed[$];
        int                    errors;

        function new();
            used    = 0;
            dropped = 0;
            errors  = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void flag(string what, logic [63:0] exp_val, logic [63:0] act_val);
            errors++;
            if (errors <= 10)
                $display("mismatch %s: expected 0x%0h, got 0x%0h", what, exp_val, act_val);
        endfunction

        // Count one accepted beat; a tlast beat closes the set and owes a report
        function void note_item(logic [ID_BITS-1:0] id, bit last);
            bit           hit;
            mode_report_t rep;
            hit = 0;
            for (int k = 0; k < used; k++) begin
                if (ids[k] == id) begin
                    // saturation needs 2^32 beats of one id; modeled, never reached here
                    if (counts[k] != COUNT_MAX)
                        counts[k] = counts[k] + 1'b1;
                    hit = 1;
                    break;
                end
            end
            if (!hit) begin
                if (used < TABLE_ENTRIES) begin
                    ids[used]    = id;
                    counts[used] = 1;
                    used++;
                end else begin
                    dropped = 1;
                end
            end
            if (!last)
                return;
            // strict compare keeps the earliest entry on ties
            rep = '0;
            for (int k = 0; k < used; k++) begin
                if (counts[k] > rep.count) begin
                    rep.count = counts[k];
                    rep.id    = ids[k];
                end
            end
            rep.distinct = used[USED_BITS-1:0];
            rep.overflow = dropped;
            owed.push_back(rep);
            used    = 0;
            dropped = 0;
        endfunction

        // Compare one output beat with the oldest owed report
        function void check_result(logic [OUT_TDATA_BITS-1:0] data);
            mode_report_t got;
            mode_report_t exp_rep;
            got = data[OUT_RAW_BITS-1:0];
            if (owed.size() == 0) begin
                flag("unexpected report", 64'd0, 64'(data));
                return;
            end
            exp_rep = owed.pop_front();
            if (got.id != exp_rep.id)
                flag("mode_id", 64'(exp_rep.id), 64'(got.id));
            if (got.count != exp_rep.count)
                flag("mode_count", 64'(exp_rep.count), 64'(got.count));
            if (got.distinct != exp_rep.distinct)
                flag("distinct_count", 64'(exp_rep.distinct), 64'(got.distinct));
            if (got.overflow != exp_rep.overflow)
                flag("table_overflow", 64'(exp_rep.overflow), 64'(got.overflow));
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic [IN_TDATA_BITS-1:0]  s_tdata;
    logic                      s_tlast;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tvalid;
    logic                      m_tready;

    mode_tally tally = new();

    int src_idle_pct;
    int rcv_idle_pct;
    int hold_left;
    int beats_sent;

    frequency_table_mode_finder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready)
    );

    // 2 ns clock
    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Offer one beat from a falling edge, hold it until taken, return at a falling edge
    task automatic send_item(input logic [ID_BITS-1:0] id, input bit last);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = IN_TDATA_BITS'(id);
        s_tlast  = last;
        do @(posedge clk); while (!s_tready);
        tally.note_item(id, last);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (tally.pending() != 0)
            @(negedge clk);
    endtask

    // Short set from a small pool so repeats and ties are common, with stray ids
    task automatic send_short_set();
        logic [ID_BITS-1:0] pool[6];
        logic [ID_BITS-1:0] id;
        int                 pool_n;
        int                 len;
        int                 roll;
        pool_n = $urandom_range(1, 6);
        len    = $urandom_range(1, 24);
        for (int i = 0; i < pool_n; i++) begin
            roll = $urandom_range(0, 19);
            pool[i] = (roll == 0) ? '0 : (roll == 1) ? '1 : ID_BITS'($urandom());
        end
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 15)
                id = ID_BITS'($urandom());
            else
                id = pool[$urandom_range(0, pool_n - 1)];
            send_item(id, i == len - 1);
        end
    endtask

    // Long set that fills the table exactly, falls just short of it or spills past it, then repeats
    task automatic send_long_set();
        logic [ID_BITS-1:0] base;
        logic [ID_BITS-1:0] stride;
        logic [ID_BITS-1:0] id;
        int                 fresh;
        int                 repeats;
        base    = ID_BITS'($urandom());
        stride  = ID_BITS'($urandom()) | 1'b1;   // odd stride keeps ids distinct
        fresh   = ($urandom_range(0, 1) == 0) ? TABLE_ENTRIES : $urandom_range(58, 72);
        repeats = $urandom_range(8, 30);
        for (int i = 0; i < fresh; i++)
            send_item(base + ID_BITS'(i) * stride, (repeats == 0) && (i == fresh - 1));
        for (int i = 0; i < repeats; i++) begin
            id = base + ID_BITS'($urandom_range(0, fresh - 1)) * stride;
            send_item(id, i == repeats - 1);
        end
    endtask

    // Result side: ready pattern at falling edges, beats checked at rising edges
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                m_tready = 1'b0;
                hold_left--;
            end else begin
                m_tready = ($urandom_range(0, 99) >= rcv_idle_pct);
            end
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                tally.check_result(m_tdata);
        end
    end

    // Stimulus
    initial begin
        bit held;
        held         = 0;
        rst_n        = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        s_tvalid     = 1'b0;
        src_idle_pct = 9;
        rcv_idle_pct = 70;
        hold_left    = 0;
        beats_sent   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // single-beat sets at both id extremes
        send_item('1, 1'b1);
        send_item('0, 1'b1);
        // tie: earliest inserted wins
        send_item(16'h1234, 1'b0);
        send_item(16'hABCD, 1'b0);
        send_item(16'hABCD, 1'b0);
        send_item(16'h1234, 1'b1);
        // later insert overtakes
        send_item(16'h0001, 1'b0);
        send_item(16'h8000, 1'b0);
        send_item(16'h8000, 1'b1);
        // alternating bit patterns
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b0);
        send_item(16'h5555, 1'b0);
        send_item(16'hAAAA, 1'b0);
        send_item(16'hAAAA, 1'b1);

        // sender waits for every report before going on
        wait_drained();
        @(negedge clk);

        while (beats_sent < 1115) begin
            if (beats_sent >= 800) begin
                src_idle_pct = 0;
                rcv_idle_pct = 0;
            end else if (beats_sent >= 420) begin
                src_idle_pct = 70;
                rcv_idle_pct = 9;
            end
            // long receiver stall while the sender keeps offering sets
            if (!held && beats_sent >= 250) begin
                held      = 1;
                hold_left = 400;
            end
            if ($urandom_range(0, 9) == 0)
                send_long_set();
            else
                send_short_set();
        end

        wait_drained();
        repeat (TABLE_ENTRIES + 16) @(posedge clk);
        if (tally.errors == 0 && tally.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial begin
        #1000000;
        $display("FAIL");
        $finish;
    end

endmodule
